// ===== rtl/ame_pkg.sv =====
// Shared types and constants for the accumulator machine execute stage.
// Holds the opcode and register-select codes, the controller state type and
// the command and status structs that join the controller and the datapath.
package ame_pkg;

   // Field widths of the request and response words.
   localparam int OP_W     = 4;
   localparam int REG_W    = 2;
   localparam int IMM_W    = 32;
   localparam int OUT_W    = 32;

   // req_tuser: op, src_is_reg, src_reg, dst_reg from the lowest bit up.
   localparam int REQ_USER_W = OP_W + 1 + REG_W + REG_W;
   // req_tdata: immediate.
   localparam int REQ_DATA_W = IMM_W;
   // rsp_tdata: print_value, step from the lowest bit up.
   localparam int RSP_DATA_W = 2 * OUT_W;
   // rsp_tuser: print_valid, div_by_zero from the lowest bit up.
   localparam int RSP_USER_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_MOV = 4'd0,
      OP_ADD = 4'd1,
      OP_SUB = 4'd2,
      OP_MUL = 4'd3,
      OP_DIV = 4'd4,
      OP_MOD = 4'd5,
      OP_JMP = 4'd6,
      OP_JEQ = 4'd7,
      OP_JLT = 4'd8,
      OP_JGT = 4'd9,
      OP_PRT = 4'd10
   } op_type;

   typedef enum logic [REG_W-1:0] {
      REG_ACC   = 2'd0,
      REG_DATA  = 2'd1,
      REG_EXTRA = 2'd2,
      REG_PC    = 2'd3
   } reg_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ITER,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;     // capture the accepted instruction
      logic start;    // seed the shift-add / restoring-divide registers
      logic step;     // one iteration of the shared bit-serial unit
      logic commit;   // write the machine registers and the response word
   } ame_cmd_type;

   typedef struct packed {
      logic needs_iter;  // multiply, or divide/modulo with a nonzero divisor
   } ame_sts_type;

endpackage

// ===== rtl/ame_ctrl.sv =====
// Controller state machine of the accumulator machine execute stage.
// Depends on ame_pkg for the state type and the command and status structs.
module ame_ctrl #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  ame_pkg::ame_sts_type sts,
   output ame_pkg::ame_cmd_type cmd
);
   import ame_pkg::*;

   localparam int CW = $clog2(DATA_WIDTH);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // The response register can take a new word when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = sts.needs_iter ? ST_ITER : ST_FINISH;
         end
         ST_ITER: begin
            if (cnt_ff == '0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DECODE: begin
            cmd.start = sts.needs_iter;
         end
         ST_ITER: begin
            cmd.step = 1'b1;
         end
         ST_FINISH: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.start) begin
         cnt_in = CW'(DATA_WIDTH - 1);
      end else if (cmd.step) begin
         cnt_in = cnt_ff - 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/ame_dpath.sv =====
// Datapath of the accumulator machine execute stage: machine registers,
// bit-serial multiply / restoring divide unit and the response register.
// Depends on ame_pkg for opcodes, register codes and command/status structs.
module ame_dpath #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ame_pkg::ame_cmd_type                cmd,
   output ame_pkg::ame_sts_type                sts,
   input  logic [ame_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [ame_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic [ame_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [ame_pkg::RSP_USER_W-1:0]      rsp_tuser
);
   import ame_pkg::*;

   localparam int DW = DATA_WIDTH;

   // Captured instruction.
   op_type                  op_ff;
   logic                    src_is_reg_ff;
   reg_sel_type             src_reg_ff;
   reg_sel_type             dst_reg_ff;
   logic signed [IMM_W-1:0] imm_ff;

   // Machine registers.
   logic [DW-1:0] acc_ff, acc_in;
   logic [DW-1:0] data_ff, data_in;
   logic [DW-1:0] extra_ff, extra_in;
   logic [DW-1:0] pc_ff, pc_in;

   // Shared iteration registers. Multiply: x multiplicand, y multiplier,
   // z product. Divide: x divisor, y dividend shifting into quotient, z remainder.
   logic [DW-1:0] x_ff, x_in;
   logic [DW-1:0] y_ff, y_in;
   logic [DW-1:0] z_ff, z_in;

   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic [DW-1:0]           reg_val, src, mag_a, mag_s, z_shift, pc_base;
   logic signed [DW-1:0]    src_s;
   logic [DW:0]             trial;
   logic                    a_neg, s_neg, src_zero, is_divmod, taken, print_valid, div_zero;
   logic signed [OUT_W-1:0] step_val;
   logic [OUT_W-1:0]        print_val;

   always_comb begin
      case (src_reg_ff)
         REG_ACC:   reg_val = acc_ff;
         REG_DATA:  reg_val = data_ff;
         REG_EXTRA: reg_val = extra_ff;
         REG_PC:    reg_val = pc_ff;
         default:   reg_val = pc_ff;
      endcase
   end

   assign src       = src_is_reg_ff ? reg_val : DW'(imm_ff);
   assign src_s     = src;
   assign a_neg     = acc_ff[DW-1];
   assign s_neg     = src[DW-1];
   assign mag_a     = a_neg ? DW'(-acc_ff) : acc_ff;
   assign mag_s     = s_neg ? DW'(-src) : src;
   assign src_zero  = (src == '0);
   assign is_divmod = (op_ff == OP_DIV) || (op_ff == OP_MOD);

   assign sts.needs_iter = (op_ff == OP_MUL) || (is_divmod && !src_zero);

   always_comb begin
      case (op_ff)
         OP_JMP:  taken = 1'b1;
         OP_JEQ:  taken = (acc_ff == '0);
         OP_JLT:  taken = a_neg;
         OP_JGT:  taken = (acc_ff != '0) && !a_neg;
         default: taken = 1'b0;
      endcase
   end

   // Jumps always take their offset from the immediate.
   assign step_val    = taken ? imm_ff : OUT_W'(1);
   assign print_valid = (op_ff == OP_PRT);
   assign print_val   = print_valid ? OUT_W'(src_s) : '0;
   assign div_zero    = is_divmod && src_zero;

   // One restoring-divide step: shift in the next dividend bit, try the subtract.
   assign z_shift = {z_ff[DW-2:0], y_ff[DW-1]};
   assign trial   = {1'b0, z_shift} - {1'b0, x_ff};

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (cmd.start) begin
         z_in = '0;
         if (op_ff == OP_MUL) begin
            x_in = acc_ff;
            y_in = src;
         end else begin
            x_in = mag_s;
            y_in = mag_a;
         end
      end else if (cmd.step) begin
         if (op_ff == OP_MUL) begin
            z_in = z_ff + (y_ff[0] ? x_ff : '0);
            x_in = {x_ff[DW-2:0], 1'b0};
            y_in = {1'b0, y_ff[DW-1:1]};
         end else if (!trial[DW]) begin
            z_in = trial[DW-1:0];
            y_in = {y_ff[DW-2:0], 1'b1};
         end else begin
            z_in = z_shift;
            y_in = {y_ff[DW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      data_in  = data_ff;
      extra_in = extra_ff;
      pc_in    = pc_ff;
      // A mov to pc replaces the base that the step is added to.
      pc_base  = ((op_ff == OP_MOV) && (dst_reg_ff == REG_PC)) ? src : pc_ff;
      if (cmd.commit) begin
         case (op_ff)
            OP_MOV: begin
               case (dst_reg_ff)
                  REG_ACC:   acc_in   = src;
                  REG_DATA:  data_in  = src;
                  REG_EXTRA: extra_in = src;
                  default:   acc_in   = acc_ff;
               endcase
            end
            OP_ADD: acc_in = acc_ff + src;
            OP_SUB: acc_in = acc_ff - src;
            OP_MUL: acc_in = z_ff;
            OP_DIV: begin
               if (!src_zero) acc_in = (a_neg ^ s_neg) ? DW'(-y_ff) : y_ff;
            end
            OP_MOD: begin
               if (!src_zero) acc_in = a_neg ? DW'(-z_ff) : z_ff;
            end
            default: acc_in = acc_ff;
         endcase
         pc_in = pc_base + DW'(step_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         data_ff  <= '0;
         extra_ff <= '0;
         pc_ff    <= '0;
      end else begin
         acc_ff   <= acc_in;
         data_ff  <= data_in;
         extra_ff <= extra_in;
         pc_ff    <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (cmd.load) begin
         op_ff         <= op_type'(req_tuser[OP_W-1:0]);
         src_is_reg_ff <= req_tuser[OP_W];
         src_reg_ff    <= reg_sel_type'(req_tuser[OP_W+REG_W:OP_W+1]);
         dst_reg_ff    <= reg_sel_type'(req_tuser[OP_W+2*REG_W:OP_W+REG_W+1]);
         imm_ff        <= req_tdata[IMM_W-1:0];
      end
      if (cmd.commit) begin
         rsp_data_ff <= {step_val, print_val};
         rsp_user_ff <= {div_zero, print_valid};
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

// ===== rtl/accumulator_machine_execute.sv =====
// Accumulator machine execute stage: one decoded instruction in, one result word out.
// Each accepted word passes through decode and finish, with an iteration phase between them
// for mul, and for div/mod with a nonzero divisor, where the one-bit-per-cycle shift-add
// multiply / restoring divide loop runs. A new request word is accepted only once the last
// word is committed to the response register. Reset clears all four registers.
// Depends on ame_pkg, ame_ctrl and ame_dpath.
module accumulator_machine_execute #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ame_pkg::REQ_DATA_W-1:0]     req_tdata,  // immediate
   input  logic [ame_pkg::REQ_USER_W-1:0]     req_tuser,  // op, src_is_reg, src_reg, dst_reg
   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ame_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // print_value, step
   output logic [ame_pkg::RSP_USER_W-1:0]     rsp_tuser   // print_valid, div_by_zero
);
   import ame_pkg::*;

   // The controller sequences each word through decode, an optional iteration
   // phase of DATA_WIDTH steps, and a commit into the response register. The
   // response register sits between the two channels, so a finished word can
   // wait on rsp_tready while the next request word is already accepted.
   ame_cmd_type cmd;
   ame_sts_type sts;

   ame_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the accumulator, data, extra and pc registers. Writing
   // pc by mov does not move fetch; the reported step is added to the new value.
   ame_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== verif/accumulator_machine_execute_test.sv =====
// Self-checking testbench for the accumulator machine execute stage.
// Drives decoded instruction words, predicts each result word with its own
// model of the four machine registers, and needs only ame_pkg and the RTL.
`timescale 1ns / 100ps

module accumulator_machine_execute_test;
   import ame_pkg::*;

   localparam int XLEN = 32;

   // Opcodes outside the defined set; the stage must treat them as no-ops.
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 4'd11;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 4'd15;

   localparam logic [XLEN-1:0] MOST_NEG = 32'h8000_0000;
   localparam logic [XLEN-1:0] MOST_POS = 32'h7FFF_FFFF;
   localparam logic [XLEN-1:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 825;
   localparam int REPORT_LIMIT  = 10;

   // One decoded instruction as it travels on the request channel.
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic             src_is_reg;
      logic [REG_W-1:0] src_reg;
      logic [IMM_W-1:0] imm;
      logic [REG_W-1:0] dst_reg;
   } instr_word_type;

   // One result word as it comes back on the response channel.
   typedef struct packed {
      logic             print_valid;
      logic [OUT_W-1:0] print_value;
      logic [OUT_W-1:0] step;
      logic             div_by_zero;
   } result_word_type;

   // A row of the directed table. Where typed is set, want is the result
   // that can be read straight off the instruction; otherwise the predictor
   // supplies the expectation.
   typedef struct packed {
      instr_word_type  ins;
      logic            typed;
      result_word_type want;
   } directed_row_type;

   localparam result_word_type STEP_ONE = '{1'b0, 32'd0, 32'd1, 1'b0};
   localparam result_word_type UNTYPED  = '0;

   // Clock, reset and the block's inputs all start at known values.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // immediate
   logic [REQ_USER_W-1:0] req_tuser  = '0;  // op, src_is_reg, src_reg, dst_reg
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // print_value, step
   logic [RSP_USER_W-1:0] rsp_tuser;        // print_valid, div_by_zero

   // Architectural state of the predictor, indexed by register code:
   // accumulator, data, extra and pc.
   logic [XLEN-1:0] mach_reg [4];

   // Expected result words in issue order; the stage answers in order.
   result_word_type pending_results [$];

   directed_row_type directed_rows [DIRECTED_ROWS];

   // While set, neither side inserts idle cycles, so back-to-back words
   // are seen as well.
   bit quiet_stretch = 1'b0;

   int error_count      = 0;
   int word_count       = 0;
   int print_count      = 0;
   int zero_div_count   = 0;
   int taken_jump_count = 0;

   always #10 clock = ~clock;

   accumulator_machine_execute #(
      .DATA_WIDTH (XLEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Executes one instruction on the predictor's registers and returns the
   // result word it must produce. Every instruction, including a mov to pc,
   // ends by adding the step to pc.
   function automatic result_word_type execute_instr(input instr_word_type ins);
      result_word_type r;
      logic [XLEN-1:0] src;
      logic [XLEN-1:0] acc;
      logic [XLEN-1:0] mag_a;
      logic [XLEN-1:0] mag_b;
      logic [XLEN-1:0] part;
      logic            jumped;
      r       = '0;
      r.step  = 32'd1;
      jumped  = 1'b0;
      acc     = mach_reg[REG_ACC];
      src     = ins.src_is_reg ? mach_reg[ins.src_reg] : ins.imm;
      case (ins.op)
         OP_MOV: mach_reg[ins.dst_reg] = src;
         OP_ADD: mach_reg[REG_ACC] = acc + src;
         OP_SUB: mach_reg[REG_ACC] = acc - src;
         OP_MUL: mach_reg[REG_ACC] = acc * src;
         OP_DIV, OP_MOD: begin
            if (src == '0) begin
               // A zero divisor leaves the accumulator alone and raises the flag.
               r.div_by_zero = 1'b1;
               zero_div_count++;
            end else begin
               // Work on magnitudes so that the most negative value divided
               // by minus one wraps instead of trapping.
               mag_a = acc[XLEN-1] ? -acc : acc;
               mag_b = src[XLEN-1] ? -src : src;
               if (ins.op == OP_DIV) begin
                  part = mag_a / mag_b;
                  mach_reg[REG_ACC] = (acc[XLEN-1] ^ src[XLEN-1]) ? -part : part;
               end else begin
                  // The remainder follows the sign of the dividend.
                  part = mag_a % mag_b;
                  mach_reg[REG_ACC] = acc[XLEN-1] ? -part : part;
               end
            end
         end
         // Jumps always take the immediate as offset, whatever the source says.
         OP_JMP: begin
            r.step = ins.imm;
            jumped = 1'b1;
         end
         OP_JEQ: if (acc == '0) begin
            r.step = ins.imm;
            jumped = 1'b1;
         end
         OP_JLT: if (acc[XLEN-1]) begin
            r.step = ins.imm;
            jumped = 1'b1;
         end
         OP_JGT: if (acc != '0 && !acc[XLEN-1]) begin
            r.step = ins.imm;
            jumped = 1'b1;
         end
         OP_PRT: begin
            r.print_valid = 1'b1;
            r.print_value = src;
            print_count++;
         end
         default: ;
      endcase
      if (jumped)
         taken_jump_count++;
      mach_reg[REG_PC] = mach_reg[REG_PC] + r.step;
      return r;
   endfunction

   // Idle lengths: mostly none or short, now and then long.
   function automatic int pick_idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_stretch || roll < 45)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Random instruction. Divide and modulo get a good share, and the
   // immediate is often small or an extreme so that zero divisors, sign
   // changes and the zero / negative / positive jump conditions all come up.
   function automatic instr_word_type make_random_instr();
      instr_word_type ins;
      int             roll;
      roll           = $urandom_range(0, 99);
      ins.src_is_reg = 1'($urandom_range(0, 1));
      ins.src_reg    = 2'($urandom_range(0, 3));
      ins.dst_reg    = 2'($urandom_range(0, 3));
      if (roll < 15)      ins.op = OP_MOV;
      else if (roll < 25) ins.op = OP_ADD;
      else if (roll < 32) ins.op = OP_SUB;
      else if (roll < 42) ins.op = OP_MUL;
      else if (roll < 54) ins.op = OP_DIV;
      else if (roll < 64) ins.op = OP_MOD;
      else if (roll < 68) ins.op = OP_JMP;
      else if (roll < 73) ins.op = OP_JEQ;
      else if (roll < 78) ins.op = OP_JLT;
      else if (roll < 83) ins.op = OP_JGT;
      else if (roll < 93) ins.op = OP_PRT;
      else                ins.op = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         ins.imm = 32'($urandom_range(0, 32)) - 32'd16;
      end else if (roll < 55) begin
         case ($urandom_range(0, 4))
            0:       ins.imm = '0;
            1:       ins.imm = 32'd1;
            2:       ins.imm = ALL_ONES;
            3:       ins.imm = MOST_NEG;
            default: ins.imm = MOST_POS;
         endcase
      end else begin
         ins.imm = $urandom();
      end
      return ins;
   endfunction

   // Presents one instruction word and holds it until the stage takes it.
   // A gap lowers tvalid first; with no gap tvalid simply stays high, so it
   // never gets two assignments in one time step. The prediction is made
   // at the accepting edge, which keeps it in issue order.
   task automatic send_instr(input instr_word_type ins, input logic typed,
                             input result_word_type want);
      int              gap;
      result_word_type predicted;
      gap = pick_idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ins.imm;
      req_tuser  <= {ins.dst_reg, ins.src_reg, ins.src_is_reg, ins.op};
      do @(posedge clock); while (!req_tready);
      predicted = execute_instr(ins);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // Compares one accepted result word with the oldest expectation.
   task automatic check_result_word();
      result_word_type got;
      result_word_type want;
      got.print_value = rsp_tdata[OUT_W-1:0];
      got.step        = rsp_tdata[2*OUT_W-1:OUT_W];
      got.print_valid = rsp_tuser[0];
      got.div_by_zero = rsp_tuser[1];
      word_count++;
      if (pending_results.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("[%0t] result word %0d arrived with nothing expected", $realtime,
                     word_count);
         return;
      end
      want = pending_results.pop_front();
      if (got.print_valid !== want.print_valid || got.print_value !== want.print_value ||
          got.step !== want.step || got.div_by_zero !== want.div_by_zero) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("[%0t] word %0d: expected prt=%b val=%h step=%h dz=%b",
                     $realtime, word_count, want.print_valid, want.print_value, want.step,
                     want.div_by_zero);
            $display("[%0t] word %0d:      got prt=%b val=%h step=%h dz=%b",
                     $realtime, word_count, got.print_valid, got.print_value, got.step,
                     got.div_by_zero);
         end
      end
   endtask

   // Response side. Handshakes are read right after the edge, before the
   // stage's own updates land, so the values seen are those of the edge.
   // Back-pressure comes in random bursts.
   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            check_result_word();
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall_left = pick_idle_cycles();
         end
      end
   end

   // Request side: reset, the directed table, then random instructions.
   initial begin : instruction_source
      foreach (mach_reg[i])
         mach_reg[i] = '0;

      // The directed rows run as one sequence, each on the registers the
      // rows before it left behind. Rows with a typed result cover the reset
      // state, zero divisors, the jump conditions at their edges and the
      // unused opcodes; the rest lean on the predictor.
      directed_rows = '{
         // Printing the accumulator right after reset shows zero.
         '{'{OP_PRT, 1'b1, REG_ACC, 32'd0, REG_ACC}, 1'b1, '{1'b1, 32'd0, 32'd1, 1'b0}},
         // Divide by an immediate zero, then modulo by the still-zero data register.
         '{'{OP_DIV, 1'b0, REG_ACC, 32'd0, REG_ACC}, 1'b1, '{1'b0, 32'd0, 32'd1, 1'b1}},
         '{'{OP_MOD, 1'b1, REG_DATA, 32'd0, REG_ACC}, 1'b1, '{1'b0, 32'd0, 32'd1, 1'b1}},
         // Largest positive plus one wraps to the most negative value.
         '{'{OP_MOV, 1'b0, REG_ACC, MOST_POS, REG_ACC}, 1'b0, UNTYPED},
         '{'{OP_ADD, 1'b0, REG_ACC, 32'd1, REG_ACC}, 1'b0, UNTYPED},
         '{'{OP_PRT, 1'b1, REG_ACC, 32'd0, REG_ACC}, 1'b1, '{1'b1, MOST_NEG, 32'd1, 1'b0}},
         // Negative accumulator: jlt takes its backward offset of minus five.
         '{'{OP_JLT, 1'b0, REG_ACC, 32'hFFFF_FFFB, REG_ACC}, 1'b1,
           '{1'b0, 32'd0, 32'hFFFF_FFFB, 1'b0}},
         '{'{OP_MOV, 1'b1, REG_ACC, 32'd0, REG_DATA}, 1'b0, UNTYPED},
         // Most negative over minus one wraps back to itself, remainder zero.
         '{'{OP_DIV, 1'b0, REG_ACC, ALL_ONES, REG_ACC}, 1'b0, UNTYPED},
         '{'{OP_PRT, 1'b1, REG_ACC, 32'd0, REG_ACC}, 1'b1, '{1'b1, MOST_NEG, 32'd1, 1'b0}},
         '{'{OP_MOD, 1'b0, REG_ACC, ALL_ONES, REG_ACC}, 1'b0, UNTYPED},
         // Zero accumulator: jeq with a zero offset stalls fetch, jgt falls through.
         '{'{OP_JEQ, 1'b0, REG_ACC, 32'd0, REG_ACC}, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0}},
         '{'{OP_JGT, 1'b0, REG_ACC, 32'd7, REG_ACC}, 1'b1, STEP_ONE},
         // Minus seven modulo two gives minus one: the sign of the dividend.
         '{'{OP_MOV, 1'b0, REG_ACC, 32'hFFFF_FFF9, REG_ACC}, 1'b0, UNTYPED},
         '{'{OP_MOD, 1'b0, REG_ACC, 32'd2, REG_ACC}, 1'b0, UNTYPED},
         '{'{OP_PRT, 1'b1, REG_ACC, 32'd0, REG_ACC}, 1'b0, UNTYPED},
         '{'{OP_SUB, 1'b0, REG_ACC, MOST_NEG, REG_ACC}, 1'b0, UNTYPED},
         // A jump with a register source still jumps by the immediate.
         '{'{OP_JGT, 1'b1, REG_DATA, MOST_POS, REG_ACC}, 1'b1, '{1'b0, 32'd0, MOST_POS, 1'b0}},
         '{'{OP_MUL, 1'b1, REG_ACC, 32'd0, REG_ACC}, 1'b0, UNTYPED},
         // Writing pc does not move fetch; the step lands on the new value.
         '{'{OP_MOV, 1'b0, REG_ACC, 32'h1234_5678, REG_PC}, 1'b0, UNTYPED},
         '{'{OP_PRT, 1'b1, REG_PC, 32'd0, REG_ACC}, 1'b0, UNTYPED},
         '{'{OP_JMP, 1'b1, REG_EXTRA, MOST_NEG, REG_ACC}, 1'b1, '{1'b0, 32'd0, MOST_NEG, 1'b0}},
         // Unused opcodes change nothing, even with pc named as destination.
         '{'{OP_UNUSED_FIRST, 1'b0, REG_ACC, ALL_ONES, REG_PC}, 1'b1, STEP_ONE},
         '{'{OP_UNUSED_LAST, 1'b1, REG_PC, MOST_NEG, REG_DATA}, 1'b1, STEP_ONE},
         // One divided by the most negative value truncates to zero.
         '{'{OP_DIV, 1'b1, REG_DATA, 32'd0, REG_ACC}, 1'b0, UNTYPED}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_instr(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].want);

      // Every fourth stretch of 80 words runs with no idling on either side.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet_stretch = ((i / 80) % 4) == 2;
         send_instr(make_random_instr(), 1'b0, UNTYPED);
      end
      quiet_stretch = 1'b0;
      req_tvalid <= 1'b0;

      // Drain, then watch a little longer for any stray result word.
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (XLEN + 8) @(posedge clock);

      $display("Sent %0d instruction words (%0d from the directed table), checked %0d results.",
               DIRECTED_ROWS + RANDOM_ITEMS, DIRECTED_ROWS, word_count);
      $display("Seen: %0d prints, %0d zero divisors, %0d taken jumps, %0d mismatches.",
               print_count, zero_div_count, taken_jump_count, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Hard stop, many times the slowest correct run.
   initial begin : watchdog
      #20_000_000;
      $display("Timed out with %0d result words still expected.", pending_results.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ame_pkg.sv
rtl/ame_ctrl.sv
rtl/ame_dpath.sv
rtl/accumulator_machine_execute.sv
verif/accumulator_machine_execute_test.sv
